// ----- rtl/srsp_pkg.sv -----
`default_nettype none
package srsp_pkg;

	typedef enum logic [4:0] {
		PH_HEADER,
		PH_PRE,
		PH_LEN_A,
		PH_LEN_B,
		PH_SKIP,
		PH_MAIN,
		PH_EXP,
		PH_AFTER_EXP,
		PH_KEY,
		PH_VAL,
		PH_STOP
	} phase_t;

	typedef enum logic [1:0] {
		DEC_WAIT,
		DEC_DONE,
		DEC_PAIR,
		DEC_BAD
	} dec_res_t;

	typedef struct packed {
		dec_res_t    res;
		logic [31:0] v;
		logic [31:0] lacc;
		logic [2:0]  lbl;
	} dec_t;

	typedef struct packed {
		logic [2:0]  kind;
		logic [63:0] payload;
		logic        last_byte;
		logic [2:0]  status;
	} res_t;

	localparam logic [2:0] KIND_NONE      = 3'd0;
	localparam logic [2:0] KIND_KEY_START = 3'd1;
	localparam logic [2:0] KIND_KEY_BYTE  = 3'd2;
	localparam logic [2:0] KIND_VAL_START = 3'd3;
	localparam logic [2:0] KIND_VAL_BYTE  = 3'd4;
	localparam logic [2:0] KIND_EXPIRY    = 3'd5;
	localparam logic [2:0] KIND_END       = 3'd6;

	localparam logic [2:0] ST_RUN      = 3'd0;
	localparam logic [2:0] ST_DONE     = 3'd1;
	localparam logic [2:0] ST_BAD_HDR  = 3'd2;
	localparam logic [2:0] ST_NO_SEL   = 3'd3;
	localparam logic [2:0] ST_BAD_TYPE = 3'd4;
	localparam logic [2:0] ST_BAD_ENC  = 3'd5;

	localparam logic [2:0] CTX_AUXK = 3'd0;
	localparam logic [2:0] CTX_AUXV = 3'd1;
	localparam logic [2:0] CTX_DB   = 3'd2;
	localparam logic [2:0] CTX_RS1  = 3'd3;
	localparam logic [2:0] CTX_RS2  = 3'd4;
	localparam logic [2:0] CTX_KEY  = 3'd5;
	localparam logic [2:0] CTX_VAL  = 3'd6;

	localparam logic [7:0] OP_STRING  = 8'h00;
	localparam logic [7:0] OP_AUX     = 8'hFA;
	localparam logic [7:0] OP_RESIZE  = 8'hFB;
	localparam logic [7:0] OP_EXP_MS  = 8'hFC;
	localparam logic [7:0] OP_EXP_SEC = 8'hFD;
	localparam logic [7:0] OP_SELDB   = 8'hFE;
	localparam logic [7:0] OP_EOF     = 8'hFF;

	localparam logic [1:0] LEN_6BIT  = 2'b00;
	localparam logic [1:0] LEN_14BIT = 2'b01;
	localparam logic [1:0] LEN_32BIT = 2'b10;
	localparam logic [1:0] LEN_SPEC  = 2'b11;

	localparam logic [5:0] SPEC_LEN1 = 6'd0;
	localparam logic [5:0] SPEC_LEN2 = 6'd1;
	localparam logic [5:0] SPEC_LEN4 = 6'd2;
	localparam logic [5:0] SPEC_PAIR = 6'd3;

	localparam logic [2:0] LBL_LONG  = 3'd4;
	localparam logic [2:0] LBL_SHORT = 3'd5;

	localparam logic [3:0] TAG_LEN = 4'd5;
	localparam logic [3:0] EXP_SEC_BYTES = 4'd4;
	localparam logic [3:0] EXP_MS_BYTES  = 4'd8;
	localparam logic [9:0] MS_PER_SEC = 10'd1000;

	function automatic logic [7:0] tag_byte(input logic [2:0] idx);
		logic [7:0] t;
		unique case (idx)
			3'd0: t = 8'h52;
			3'd1: t = 8'h45;
			3'd2: t = 8'h44;
			3'd3: t = 8'h49;
			3'd4: t = 8'h53;
			default: t = 8'h00;
		endcase
		return t;
	endfunction

	function automatic dec_t decode_len(input logic [2:0] lbl, input logic [31:0] lacc,
			input logic [7:0] b);
		dec_t d;
		d.res  = DEC_WAIT;
		d.v    = '0;
		d.lacc = lacc;
		d.lbl  = lbl;
		if (lbl == 3'd0) begin
			unique case (b[7:6])
				LEN_6BIT: begin
					d.v   = {26'd0, b[5:0]};
					d.res = DEC_DONE;
				end
				LEN_14BIT: begin
					d.lacc = {26'd0, b[5:0]};
					d.lbl  = LBL_SHORT;
				end
				LEN_32BIT: begin
					d.lacc = '0;
					d.lbl  = LBL_LONG;
				end
				LEN_SPEC: begin
					unique case (b[5:0])
						SPEC_LEN1: begin
							d.v   = 32'd1;
							d.res = DEC_DONE;
						end
						SPEC_LEN2: begin
							d.v   = 32'd2;
							d.res = DEC_DONE;
						end
						SPEC_LEN4: begin
							d.v   = 32'd4;
							d.res = DEC_DONE;
						end
						SPEC_PAIR: d.res = DEC_PAIR;
						default:   d.res = DEC_BAD;
					endcase
				end
				default: d.res = DEC_BAD;
			endcase
		end else if (lbl >= LBL_SHORT) begin
			d.v   = {18'd0, lacc[5:0], b};
			d.lbl = 3'd0;
			d.res = DEC_DONE;
		end else begin
			d.lacc = {b, lacc[31:8]};
			d.lbl  = lbl - 3'd1;
			if (d.lbl == 3'd0) begin
				d.v   = d.lacc;
				d.res = DEC_DONE;
			end
		end
		return d;
	endfunction

endpackage
`default_nettype wire

// ----- rtl/srsp_step.sv -----
`default_nettype none
module srsp_step #(
	parameter int unsigned HEADER_LENGTH = 9
) (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         step_en,
	input  wire logic [7:0]   in_byte,
	input  wire logic         start_of_file,
	output srsp_pkg::res_t    res
);
	import srsp_pkg::*;

	phase_t      phase_q, cur_phase, nxt_phase;
	logic [3:0]  hc_q, cur_hc, nxt_hc;
	logic [31:0] lacc_q, cur_lacc, nxt_lacc;
	logic [2:0]  lbl_q, cur_lbl, nxt_lbl;
	logic [31:0] slb_q, cur_slb, nxt_slb;
	logic [63:0] eacc_q, cur_eacc, nxt_eacc;
	logic [3:0]  ebl_q, cur_ebl, nxt_ebl;
	logic [2:0]  ctx_q, cur_ctx, nxt_ctx;
	logic        slp_q, cur_slp, nxt_slp;
	logic        eis_q, cur_eis, nxt_eis;

	dec_t        dec;
	logic        do_fin;
	logic [31:0] fin_v;
	logic        do_start;
	logic [2:0]  eidx;
	logic [63:0] eacc_new;
	logic [41:0] ms_sec;
	logic [3:0]  hc_inc;
	logic [31:0] slb_dec;
	logic [3:0]  ebl_dec;

	assign cur_phase = start_of_file ? PH_HEADER : phase_q;
	assign cur_hc    = start_of_file ? 4'd0 : hc_q;
	assign cur_lacc  = start_of_file ? 32'd0 : lacc_q;
	assign cur_lbl   = start_of_file ? 3'd0 : lbl_q;
	assign cur_slb   = start_of_file ? 32'd0 : slb_q;
	assign cur_eacc  = start_of_file ? 64'd0 : eacc_q;
	assign cur_ebl   = start_of_file ? 4'd0 : ebl_q;
	assign cur_ctx   = start_of_file ? CTX_AUXK : ctx_q;
	assign cur_slp   = start_of_file ? 1'b0 : slp_q;
	assign cur_eis   = start_of_file ? 1'b0 : eis_q;

	assign dec     = decode_len(cur_lbl, cur_lacc, in_byte);
	assign hc_inc  = cur_hc + 4'd1;
	assign slb_dec = cur_slb - 32'd1;
	assign ebl_dec = cur_ebl - 4'd1;
	assign eidx    = 3'((cur_eis ? EXP_SEC_BYTES : EXP_MS_BYTES) - cur_ebl);
	assign ms_sec  = 42'(eacc_new[31:0]) * 42'(MS_PER_SEC);

	always_comb begin
		eacc_new = cur_eacc;
		for (int i = 0; i < 8; i++) begin
			if (eidx == 3'(i)) begin
				eacc_new[i*8 +: 8] = cur_eacc[i*8 +: 8] | in_byte;
			end
		end
	end

	always_comb begin
		nxt_phase = cur_phase;
		nxt_hc    = cur_hc;
		nxt_lacc  = cur_lacc;
		nxt_lbl   = cur_lbl;
		nxt_slb   = cur_slb;
		nxt_eacc  = cur_eacc;
		nxt_ebl   = cur_ebl;
		nxt_ctx   = cur_ctx;
		nxt_slp   = cur_slp;
		nxt_eis   = cur_eis;
		do_fin    = 1'b0;
		fin_v     = '0;
		do_start  = 1'b0;
		res.kind      = KIND_NONE;
		res.payload   = '0;
		res.last_byte = 1'b0;
		res.status    = ST_RUN;

		unique case (cur_phase)
			PH_HEADER: begin
				if (cur_hc < TAG_LEN && in_byte != tag_byte(cur_hc[2:0])) begin
					nxt_phase  = PH_STOP;
					nxt_ctx    = ST_BAD_HDR;
					res.status = ST_BAD_HDR;
				end else begin
					nxt_hc = hc_inc;
					if (hc_inc >= 4'(HEADER_LENGTH)) begin
						nxt_phase = PH_PRE;
					end
				end
			end
			PH_PRE: begin
				if (in_byte == OP_AUX) begin
					nxt_ctx  = CTX_AUXK;
					do_start = 1'b1;
				end else if (in_byte == OP_SELDB) begin
					nxt_ctx  = CTX_DB;
					do_start = 1'b1;
				end else begin
					nxt_phase  = PH_STOP;
					nxt_ctx    = ST_NO_SEL;
					res.status = ST_NO_SEL;
				end
			end
			PH_LEN_A: begin
				nxt_lacc = dec.lacc;
				nxt_lbl  = dec.lbl;
				unique case (dec.res)
					DEC_BAD: begin
						nxt_phase  = PH_STOP;
						nxt_ctx    = ST_BAD_ENC;
						res.status = ST_BAD_ENC;
					end
					DEC_PAIR: begin
						if (cur_slp) begin
							nxt_phase  = PH_STOP;
							nxt_ctx    = ST_BAD_ENC;
							res.status = ST_BAD_ENC;
						end else begin
							nxt_slp = 1'b1;
						end
					end
					DEC_DONE: begin
						if (cur_slp) begin
							nxt_slb   = dec.v;
							nxt_slp   = 1'b0;
							nxt_lbl   = 3'd0;
							nxt_lacc  = '0;
							nxt_phase = PH_LEN_B;
						end else begin
							do_fin = 1'b1;
							fin_v  = dec.v;
						end
					end
					default: ;
				endcase
			end
			PH_LEN_B: begin
				nxt_lacc = dec.lacc;
				nxt_lbl  = dec.lbl;
				if (dec.res == DEC_BAD || dec.res == DEC_PAIR) begin
					nxt_phase  = PH_STOP;
					nxt_ctx    = ST_BAD_ENC;
					res.status = ST_BAD_ENC;
				end else if (dec.res == DEC_DONE) begin
					do_fin = 1'b1;
					fin_v  = cur_slb;
				end
			end
			PH_SKIP: begin
				nxt_slb = slb_dec;
				if (slb_dec == 32'd0) begin
					if (cur_ctx == CTX_AUXK) begin
						nxt_ctx  = CTX_AUXV;
						do_start = 1'b1;
					end else begin
						nxt_phase = PH_PRE;
					end
				end
			end
			PH_MAIN: begin
				if (in_byte == OP_EOF) begin
					res.kind   = KIND_END;
					res.status = ST_DONE;
					nxt_phase  = PH_STOP;
					nxt_ctx    = ST_DONE;
				end else if (in_byte == OP_RESIZE) begin
					nxt_ctx  = CTX_RS1;
					do_start = 1'b1;
				end else if (in_byte == OP_EXP_MS || in_byte == OP_EXP_SEC) begin
					nxt_eis   = (in_byte == OP_EXP_SEC);
					nxt_ebl   = (in_byte == OP_EXP_SEC) ? EXP_SEC_BYTES : EXP_MS_BYTES;
					nxt_eacc  = '0;
					nxt_phase = PH_EXP;
				end else if (in_byte == OP_STRING) begin
					nxt_ctx  = CTX_KEY;
					do_start = 1'b1;
				end else begin
					nxt_phase  = PH_STOP;
					nxt_ctx    = ST_BAD_TYPE;
					res.status = ST_BAD_TYPE;
				end
			end
			PH_EXP: begin
				nxt_eacc = eacc_new;
				nxt_ebl  = ebl_dec;
				if (ebl_dec == 4'd0) begin
					res.kind    = KIND_EXPIRY;
					res.payload = cur_eis ? 64'(ms_sec) : eacc_new;
					nxt_phase   = PH_AFTER_EXP;
				end
			end
			PH_AFTER_EXP: begin
				if (in_byte == OP_STRING) begin
					nxt_ctx  = CTX_KEY;
					do_start = 1'b1;
				end else begin
					nxt_phase  = PH_STOP;
					nxt_ctx    = ST_BAD_TYPE;
					res.status = ST_BAD_TYPE;
				end
			end
			PH_KEY, PH_VAL: begin
				res.kind    = (cur_phase == PH_KEY) ? KIND_KEY_BYTE : KIND_VAL_BYTE;
				res.payload = {56'd0, in_byte};
				nxt_slb     = slb_dec;
				if (slb_dec == 32'd0) begin
					res.last_byte = 1'b1;
					if (cur_phase == PH_KEY) begin
						nxt_ctx  = CTX_VAL;
						do_start = 1'b1;
					end else begin
						nxt_phase = PH_MAIN;
					end
				end
			end
			PH_STOP: begin
				res.status = cur_ctx;
			end
			default: begin
				nxt_phase = PH_HEADER;
				nxt_hc    = '0;
				nxt_lacc  = '0;
				nxt_lbl   = '0;
				nxt_slb   = '0;
				nxt_eacc  = '0;
				nxt_ebl   = '0;
				nxt_ctx   = CTX_AUXK;
				nxt_slp   = 1'b0;
				nxt_eis   = 1'b0;
			end
		endcase

		if (do_fin) begin
			unique case (cur_ctx)
				CTX_AUXK: begin
					nxt_slb = fin_v;
					if (fin_v == 32'd0) begin
						nxt_ctx  = CTX_AUXV;
						do_start = 1'b1;
					end else begin
						nxt_phase = PH_SKIP;
					end
				end
				CTX_AUXV: begin
					nxt_slb   = fin_v;
					nxt_phase = (fin_v == 32'd0) ? PH_PRE : PH_SKIP;
				end
				CTX_RS1: begin
					nxt_ctx  = CTX_RS2;
					do_start = 1'b1;
				end
				CTX_KEY: begin
					res.kind      = KIND_KEY_START;
					res.payload   = {32'd0, fin_v};
					res.last_byte = (fin_v == 32'd0);
					nxt_slb       = fin_v;
					if (fin_v == 32'd0) begin
						nxt_ctx  = CTX_VAL;
						do_start = 1'b1;
					end else begin
						nxt_phase = PH_KEY;
					end
				end
				CTX_VAL: begin
					res.kind      = KIND_VAL_START;
					res.payload   = {32'd0, fin_v};
					res.last_byte = (fin_v == 32'd0);
					nxt_slb       = fin_v;
					nxt_phase     = (fin_v == 32'd0) ? PH_MAIN : PH_VAL;
				end
				default: nxt_phase = PH_MAIN;
			endcase
		end

		if (do_start) begin
			nxt_phase = PH_LEN_A;
			nxt_lbl   = 3'd0;
			nxt_lacc  = '0;
			nxt_slp   = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_HEADER;
			hc_q    <= '0;
			lacc_q  <= '0;
			lbl_q   <= '0;
			slb_q   <= '0;
			eacc_q  <= '0;
			ebl_q   <= '0;
			ctx_q   <= CTX_AUXK;
			slp_q   <= 1'b0;
			eis_q   <= 1'b0;
		end else if (step_en) begin
			phase_q <= nxt_phase;
			hc_q    <= nxt_hc;
			lacc_q  <= nxt_lacc;
			lbl_q   <= nxt_lbl;
			slb_q   <= nxt_slb;
			eacc_q  <= nxt_eacc;
			ebl_q   <= nxt_ebl;
			ctx_q   <= nxt_ctx;
			slp_q   <= nxt_slp;
			eis_q   <= nxt_eis;
		end
	end

endmodule
`default_nettype wire

// ----- rtl/snapshot_record_stream_parser.sv -----
// A taken word is held in the input register; its result word is registered for out_valid.
// Throughput: one input word per cycle while out_stall is low; one result per input word.
// The rate is set by the combinational parser step between the input and result registers.
// Reset (arst_n low) clears both stages and returns the parser to the header phase.
// start_of_file high on a word restarts parsing with that word as header byte 0.
`default_nettype none
module snapshot_record_stream_parser #(
	parameter int unsigned HEADER_LENGTH = 9
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_stall,
	input  wire logic [7:0]  in_byte,
	input  wire logic        start_of_file,
	output logic             out_valid,
	input  wire logic        out_stall,
	output logic [2:0]       kind,
	output logic [63:0]      payload,
	output logic             last_byte,
	output logic [2:0]       status
);
	import srsp_pkg::*;

	logic       valid_s1;
	logic [7:0] byte_s1;
	logic       sof_s1;
	logic       adv;
	logic       in_take;
	res_t       step_res;
	res_t       res_s2;

	assign adv      = valid_s1 && (!out_valid || !out_stall);
	assign in_stall = valid_s1 && !adv;
	assign in_take  = in_valid && !in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= in_take || (valid_s1 && !adv);
		end
	end

	always_ff @(posedge clk) begin
		if (in_take) begin
			byte_s1 <= in_byte;
			sof_s1  <= start_of_file;
		end
	end

	srsp_step #(
		.HEADER_LENGTH(HEADER_LENGTH)
	) u_step (
		.clk(clk),
		.arst_n(arst_n),
		.step_en(adv),
		.in_byte(byte_s1),
		.start_of_file(sof_s1),
		.res(step_res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else begin
			out_valid <= adv || (out_valid && out_stall);
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			res_s2 <= step_res;
		end
	end

	assign kind      = res_s2.kind;
	assign payload   = res_s2.payload;
	assign last_byte = res_s2.last_byte;
	assign status    = res_s2.status;

	a_hold_s1: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !adv |=> valid_s1 && $stable(byte_s1) && $stable(sof_s1))
		else $error("input stage lost a held word");

	a_adv_out: assert property (@(posedge clk) disable iff (!arst_n)
		adv |=> out_valid)
		else $error("step result not presented");

	a_last_kind: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && last_byte |-> kind == KIND_KEY_START || kind == KIND_KEY_BYTE ||
			kind == KIND_VAL_START || kind == KIND_VAL_BYTE)
		else $error("last_byte on a word that is no string word");

	a_stop_kind: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status != ST_RUN |-> kind == KIND_NONE || kind == KIND_END)
		else $error("data word with a terminal status");

endmodule
`default_nettype wire
